@@ sv/lavm_pkg.sv @@
// Shared types for the look-at view matrix block.
package lavm_pkg;

	localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

	// One classified item as it travels from the front to the back.
	typedef struct packed {
		logic [2:0][31:0] eye;
		logic [2:0][31:0] up;
		logic [2:0][32:0] dif;
		logic             ident;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

@@ sv/lavm_front.sv @@
// Front end: take the command beat, form eye - target and flag the identity case.
module lavm_front import lavm_pkg::*; (
	input  logic               start,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] upward_x,
	input  logic signed [31:0] upward_y,
	input  logic signed [31:0] upward_z,
	input  qstat_t             qstat,
	output logic               busy,
	output logic               push,
	output item_t              item
);

	logic signed [32:0] dx, dy, dz;

	assign dx = 33'(eye_x) - 33'(target_x);
	assign dy = 33'(eye_y) - 33'(target_y);
	assign dz = 33'(eye_z) - 33'(target_z);

	assign busy = qstat.full;
	assign push = start & ~qstat.full;

	always_comb begin
		item.eye[0] = eye_x;
		item.eye[1] = eye_y;
		item.eye[2] = eye_z;
		item.up[0]  = upward_x;
		item.up[1]  = upward_y;
		item.up[2]  = upward_z;
		item.dif[0] = dx;
		item.dif[1] = dy;
		item.dif[2] = dz;
		// eye on target: skip the maths and send the identity
		item.ident  = (dx == '0) && (dy == '0) && (dz == '0);
	end

endmodule

@@ sv/lavm_queue.sv @@
// Two-entry queue between the front end and the matrix engine.
module lavm_queue import lavm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  item_t  wr,
	input  logic   pop,
	output item_t  rd,
	output qstat_t stat
);

	localparam int unsigned DEPTH = 2;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	item_t          slot_q [DEPTH];
	logic [AW-1:0]  wp_q, rp_q;
	logic [CW-1:0]  cnt_q;

	assign rd         = slot_q[rp_q];
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/lavm_back.sv @@
// Matrix engine: normalise, cross, dot products and the four result beats.
module lavm_back import lavm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  item_t              item,
	input  qstat_t             qstat,
	output logic               pop,
	output logic               strobe,
	output logic signed [31:0] elem_a,
	output logic signed [31:0] elem_b,
	output logic signed [31:0] elem_c,
	output logic signed [31:0] elem_d,
	output logic               last_group
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_NMAG   = 11'b000_0000_0010,
		S_NSHIFT = 11'b000_0000_0100,
		S_MAC    = 11'b000_0000_1000,
		S_MEND   = 11'b000_0001_0000,
		S_SQRT   = 11'b000_0010_0000,
		S_DSET   = 11'b000_0100_0000,
		S_DIV    = 11'b000_1000_0000,
		S_DWR    = 11'b001_0000_0000,
		S_NEXT   = 11'b010_0000_0000,
		S_OUT    = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {VS_Z, VS_X, VS_Y} vsel_t;
	typedef enum logic [1:0] {J_SQ, J_CR1, J_CR2, J_DOT} job_t;

	function automatic logic [1:0] nxt3(input logic [1:0] i);
		case (i)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sel32(input logic [1:0] i,
			input logic signed [31:0] v0, input logic signed [31:0] v1,
			input logic signed [31:0] v2);
		case (i)
			2'd0:    return v0;
			2'd1:    return v1;
			default: return v2;
		endcase
	endfunction

	function automatic logic signed [17:0] sel18(input logic [1:0] i,
			input logic signed [17:0] v0, input logic signed [17:0] v1,
			input logic signed [17:0] v2);
		case (i)
			2'd0:    return v0;
			2'd1:    return v1;
			default: return v2;
		endcase
	endfunction

	state_t             st_q;
	vsel_t              vs_q;
	job_t               job_q;
	logic [1:0]         ci_q, oi_q, k_q;
	logic [4:0]         stp_q;
	logic               strobe_q;

	logic signed [31:0] eye_q [3];
	logic signed [31:0] up_q  [3];
	logic signed [49:0] v_q   [3];
	logic [48:0]        a_q   [3];
	logic               sg_q  [3];
	logic signed [17:0] z_q   [3];
	logic signed [17:0] x_q   [3];
	logic signed [17:0] y_q   [3];
	logic signed [31:0] m_q   [3];
	logic               ident_q;

	logic signed [62:0] prod_q;
	logic               pneg_q;
	logic signed [63:0] acc_q;
	logic [63:0]        n_q, r_q, bit_q;
	logic [47:0]        rem_q, dvs_q;
	logic [16:0]        qt_q;

	logic signed [31:0] ea_q, eb_q, ec_q, ed_q;
	logic               last_q;

	logic [1:0]         i1, i2;
	logic signed [31:0] mul_a;
	logic signed [30:0] mul_b;
	logic               mneg;
	logic [1:0]         nops;
	logic [29:0]        sa_op, sa_ci;
	logic signed [17:0] nvec;
	logic               big, tiny, vzero, sq_ge, div_ge, sg_ci;
	logic [63:0]        sq_sum;
	logic signed [17:0] qres;
	logic [49:0]        dmag;
	logic [34:0]        dq;
	logic signed [31:0] dot_res;

	assign pop        = (st_q == S_IDLE) && !qstat.empty;
	assign strobe     = strobe_q;
	assign elem_a     = ea_q;
	assign elem_b     = eb_q;
	assign elem_c     = ec_q;
	assign elem_d     = ed_q;
	assign last_group = last_q;

	assign i1 = nxt3(ci_q);
	assign i2 = nxt3(i1);

	always_comb begin
		case (oi_q)
			2'd0:    sa_op = a_q[0][29:0];
			2'd1:    sa_op = a_q[1][29:0];
			default: sa_op = a_q[2][29:0];
		endcase
		case (ci_q)
			2'd0:    begin sa_ci = a_q[0][29:0]; sg_ci = sg_q[0]; end
			2'd1:    begin sa_ci = a_q[1][29:0]; sg_ci = sg_q[1]; end
			default: begin sa_ci = a_q[2][29:0]; sg_ci = sg_q[2]; end
		endcase
		case (ci_q)
			2'd0:    nvec = sel18(oi_q, x_q[0], x_q[1], x_q[2]);
			2'd1:    nvec = sel18(oi_q, y_q[0], y_q[1], y_q[2]);
			default: nvec = sel18(oi_q, z_q[0], z_q[1], z_q[2]);
		endcase
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mneg  = 1'b0;
		nops  = 2'd3;
		case (job_q)
			J_SQ: begin
				mul_a = $signed({2'b00, sa_op});
				mul_b = $signed({1'b0, sa_op});
			end
			J_CR1: begin
				nops = 2'd2;
				if (oi_q == 2'd0) begin
					mul_a = sel32(i1, up_q[0], up_q[1], up_q[2]);
					mul_b = 31'(sel18(i2, z_q[0], z_q[1], z_q[2]));
				end else begin
					mul_a = sel32(i2, up_q[0], up_q[1], up_q[2]);
					mul_b = 31'(sel18(i1, z_q[0], z_q[1], z_q[2]));
					mneg  = 1'b1;
				end
			end
			J_CR2: begin
				nops = 2'd2;
				if (oi_q == 2'd0) begin
					mul_a = 32'(sel18(i1, z_q[0], z_q[1], z_q[2]));
					mul_b = 31'(sel18(i2, x_q[0], x_q[1], x_q[2]));
				end else begin
					mul_a = 32'(sel18(i2, z_q[0], z_q[1], z_q[2]));
					mul_b = 31'(sel18(i1, x_q[0], x_q[1], x_q[2]));
					mneg  = 1'b1;
				end
			end
			J_DOT: begin
				mul_a = sel32(oi_q, eye_q[0], eye_q[1], eye_q[2]);
				mul_b = 31'(nvec);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	always_comb begin
		big    = (|a_q[0][48:30]) | (|a_q[1][48:30]) | (|a_q[2][48:30]);
		tiny   = (a_q[0][48:29] == '0) && (a_q[1][48:29] == '0) && (a_q[2][48:29] == '0);
		vzero  = (v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0);
		sq_sum = r_q + bit_q;
		sq_ge  = (n_q >= sq_sum);
		div_ge = (rem_q >= dvs_q);
		qres   = sg_ci ? -$signed({1'b0, qt_q}) : $signed({1'b0, qt_q});
		// negated dot product, round half away from zero, then saturate
		dmag   = acc_q[63] ? 50'(-acc_q) : acc_q[49:0];
		dq     = 35'((51'(dmag) + 51'd32768) >> 16);
		if (acc_q > 0) begin
			dot_res = (dq > 35'h0_8000_0000) ? 32'sh8000_0000 : -$signed(dq[31:0]);
		end else begin
			dot_res = (dq > 35'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq[31:0]);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			vs_q     <= VS_Z;
			job_q    <= J_SQ;
			ci_q     <= '0;
			oi_q     <= '0;
			k_q      <= '0;
			stp_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (!qstat.empty) begin
						vs_q <= VS_Z;
						k_q  <= '0;
						ci_q <= '0;
						st_q <= item.ident ? S_OUT : S_NMAG;
					end
				end
				S_NMAG: st_q <= vzero ? S_NEXT : S_NSHIFT;
				S_NSHIFT: begin
					if (!big && !tiny) begin
						job_q <= J_SQ;
						oi_q  <= '0;
						st_q  <= S_MAC;
					end
				end
				S_MAC: begin
					if (oi_q == nops) begin
						st_q <= S_MEND;
					end else begin
						oi_q <= oi_q + 1'b1;
					end
				end
				S_MEND: begin
					oi_q <= '0;
					case (job_q)
						J_SQ: st_q <= S_SQRT;
						J_DOT: begin
							if (ci_q == 2'd2) begin
								k_q  <= '0;
								st_q <= S_OUT;
							end else begin
								ci_q <= ci_q + 1'b1;
								st_q <= S_MAC;
							end
						end
						default: begin
							if (ci_q == 2'd2) begin
								ci_q <= '0;
								st_q <= S_NMAG;
							end else begin
								ci_q <= ci_q + 1'b1;
								st_q <= S_MAC;
							end
						end
					endcase
				end
				S_SQRT: begin
					if (bit_q[0]) begin
						ci_q <= '0;
						st_q <= S_DSET;
					end
				end
				S_DSET: begin
					stp_q <= '0;
					st_q  <= S_DIV;
				end
				S_DIV: begin
					if (stp_q == 5'd16) begin
						st_q <= S_DWR;
					end else begin
						stp_q <= stp_q + 1'b1;
					end
				end
				S_DWR: begin
					if (ci_q == 2'd2) begin
						ci_q <= '0;
						st_q <= S_NEXT;
					end else begin
						ci_q <= ci_q + 1'b1;
						st_q <= S_DSET;
					end
				end
				S_NEXT: begin
					ci_q <= '0;
					oi_q <= '0;
					st_q <= S_MAC;
					case (vs_q)
						VS_Z: begin
							job_q <= J_CR1;
							vs_q  <= VS_X;
						end
						VS_X: begin
							job_q <= J_CR2;
							vs_q  <= VS_Y;
						end
						default: job_q <= J_DOT;
					endcase
				end
				S_OUT: begin
					strobe_q <= 1'b1;
					if (k_q == 2'd3) begin
						st_q <= S_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				if (!qstat.empty) begin
					for (int i = 0; i < 3; i++) begin
						eye_q[i] <= item.eye[i];
						up_q[i]  <= item.up[i];
						v_q[i]   <= 50'($signed(item.dif[i]));
					end
					ident_q <= item.ident;
				end
			end
			S_NMAG: begin
				for (int i = 0; i < 3; i++) begin
					a_q[i]  <= v_q[i][49] ? 49'(-v_q[i]) : v_q[i][48:0];
					sg_q[i] <= v_q[i][49];
					// zero-length vector normalises to zero
					if (vzero) begin
						case (vs_q)
							VS_Z:    z_q[i] <= '0;
							VS_X:    x_q[i] <= '0;
							default: y_q[i] <= '0;
						endcase
					end
				end
			end
			S_NSHIFT: begin
				for (int i = 0; i < 3; i++) begin
					if (big) begin
						a_q[i] <= a_q[i] >> 1;
					end else if (tiny) begin
						a_q[i] <= a_q[i] << 1;
					end
				end
			end
			S_MAC: begin
				prod_q <= 63'(mul_a) * 63'(mul_b);
				pneg_q <= mneg;
				if (oi_q == 2'd0) begin
					acc_q <= '0;
				end else if (pneg_q) begin
					acc_q <= acc_q - 64'(prod_q);
				end else begin
					acc_q <= acc_q + 64'(prod_q);
				end
			end
			S_MEND: begin
				case (job_q)
					J_SQ: begin
						n_q   <= acc_q;
						r_q   <= '0;
						bit_q <= 64'd1 << 62;
					end
					J_DOT: begin
						for (int i = 0; i < 3; i++) begin
							if (ci_q == 2'(i)) m_q[i] <= dot_res;
						end
					end
					default: begin
						for (int i = 0; i < 3; i++) begin
							if (ci_q == 2'(i)) v_q[i] <= acc_q[49:0];
						end
					end
				endcase
			end
			S_SQRT: begin
				if (sq_ge) begin
					n_q <= n_q - sq_sum;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DSET: begin
				rem_q <= 48'({sa_ci, 16'h0000}) + 48'(r_q[31:1]);
				dvs_q <= 48'(r_q[31:0]) << 16;
				qt_q  <= '0;
			end
			S_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dvs_q;
				end
				qt_q  <= {qt_q[15:0], div_ge};
				dvs_q <= dvs_q >> 1;
			end
			S_DWR: begin
				for (int i = 0; i < 3; i++) begin
					if (ci_q == 2'(i)) begin
						case (vs_q)
							VS_Z:    z_q[i] <= qres;
							VS_X:    x_q[i] <= qres;
							default: y_q[i] <= qres;
						endcase
					end
				end
			end
			S_OUT: begin
				last_q <= (k_q == 2'd3);
				if (ident_q) begin
					ea_q <= (k_q == 2'd0) ? ONE_Q16 : '0;
					eb_q <= (k_q == 2'd1) ? ONE_Q16 : '0;
					ec_q <= (k_q == 2'd2) ? ONE_Q16 : '0;
					ed_q <= (k_q == 2'd3) ? ONE_Q16 : '0;
				end else if (k_q == 2'd3) begin
					ea_q <= m_q[0];
					eb_q <= m_q[1];
					ec_q <= m_q[2];
					ed_q <= ONE_Q16;
				end else begin
					ea_q <= 32'(sel18(k_q, x_q[0], x_q[1], x_q[2]));
					eb_q <= 32'(sel18(k_q, y_q[0], y_q[1], y_q[2]));
					ec_q <= 32'(sel18(k_q, z_q[0], z_q[1], z_q[2]));
					ed_q <= '0;
				end
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

endmodule

@@ sv/look_at_view_matrix_top.sv @@
// Look-at view matrix: eye, target and up in, 4x4 matrix out as four beats.
//
// Input: drive the nine Q16.16 fields and raise start; the beat is taken
// on a clock edge where start is high and busy is low. The front end forms
// eye - target and pushes into a two-entry queue, so up to two commands
// are taken while the engine works; busy is high only while it is full.
// Output: each matrix row group appears for one cycle with strobe high;
// the four beats of one item come back to back, last_group
// marks the fourth (translation) beat. The receiver cannot stall.
// Work after pop: the identity case (eye equals target) goes straight to
// the output beats; otherwise there are three normalisations, each a shift
// search, a 32-step bit-serial square root and three 17-step restoring
// divisions (a zero vector skips them), plus the cross and dot products on
// one shared multiplier.
// The engine works on one item at a time and pops the next only when idle.
// Reset: arst_n clears the queue and the sequencer; no beat follows reset.
module look_at_view_matrix_top import lavm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] upward_x,
	input  logic signed [31:0] upward_y,
	input  logic signed [31:0] upward_z,
	output logic               strobe,
	output logic signed [31:0] elem_a,
	output logic signed [31:0] elem_b,
	output logic signed [31:0] elem_c,
	output logic signed [31:0] elem_d,
	output logic               last_group
);

	qstat_t qstat;
	item_t  wr_item, rd_item;
	logic   push, pop;

	lavm_front u_front (
		.start    (start),
		.eye_x    (eye_x),
		.eye_y    (eye_y),
		.eye_z    (eye_z),
		.target_x (target_x),
		.target_y (target_y),
		.target_z (target_z),
		.upward_x (upward_x),
		.upward_y (upward_y),
		.upward_z (upward_z),
		.qstat    (qstat),
		.busy     (busy),
		.push     (push),
		.item     (wr_item)
	);

	lavm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr     (wr_item),
		.pop    (pop),
		.rd     (rd_item),
		.stat   (qstat)
	);

	lavm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (rd_item),
		.qstat      (qstat),
		.pop        (pop),
		.strobe     (strobe),
		.elem_a     (elem_a),
		.elem_b     (elem_b),
		.elem_c     (elem_c),
		.elem_d     (elem_d),
		.last_group (last_group)
	);

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_group |=> !strobe)
		else $error("beat followed the last group");

	a_group_runs: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_group |=> strobe)
		else $error("gap inside a result group");

	a_pop_space: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("push into full queue");

endmodule

@@ verif/look_at_view_matrix_top_tb.sv @@
// Testbench for the look-at view matrix block: directed table, random commands, checked beats.
`timescale 1ns / 100ps

module look_at_view_matrix_top_tb import lavm_pkg::*; ();

	typedef struct {
		logic signed [31:0] eye [3];
		logic signed [31:0] tgt [3];
		logic signed [31:0] up [3];
	} view_cmd_t;

	typedef struct {
		logic signed [31:0] e [4];
		logic               last;
	} matrix_beat_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] eye_x, eye_y, eye_z;
	logic signed [31:0] target_x, target_y, target_z;
	logic signed [31:0] upward_x, upward_y, upward_z;
	logic               strobe;
	logic signed [31:0] elem_a, elem_b, elem_c, elem_d;
	logic               last_group;

	matrix_beat_t pending_beats [$];
	int           mismatches;
	int           beats_seen;

	look_at_view_matrix_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [63:0] mag_of(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Scale to [2^29, 2^30), then divide by the rounded-down length.
	function automatic void unit_vec(input logic signed [63:0] v [3],
			output logic signed [63:0] u [3]);
		logic [63:0] a [3];
		logic [63:0] mx, s, len, q;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = mag_of(v[i]);
			if (a[i] > mx) mx = a[i];
		end
		if (mx == 0) begin
			for (int i = 0; i < 3; i++) u[i] = 0;
			return;
		end
		while (mx >= (64'd1 << 30)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
		end
		while (mx < (64'd1 << 29)) begin
			mx = mx << 1;
			for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
		end
		s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = (a[i] * 64'd65536 + (len >> 1)) / len;
			u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
		end
	endfunction

	function automatic void cross_full(input logic signed [63:0] a [3],
			input logic signed [63:0] b [3], output logic signed [63:0] o [3]);
		o[0] = a[1] * b[2] - a[2] * b[1];
		o[1] = a[2] * b[0] - a[0] * b[2];
		o[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic logic signed [31:0] eye_offset(logic signed [63:0] n [3],
			logic signed [63:0] e [3]);
		logic signed [63:0] d;
		logic [63:0]        q;
		d = -(n[0] * e[0] + n[1] * e[1] + n[2] * e[2]);
		q = (mag_of(d) + 64'd32768) >> 16;
		if (d < 0) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'(-$signed(q));
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return 32'(q);
	endfunction

	task automatic predict_view(input view_cmd_t c);
		logic signed [63:0] eye [3], up [3], d [3], z [3], x [3], y [3], t [3];
		logic signed [31:0] m [16];
		matrix_beat_t       b;
		for (int i = 0; i < 3; i++) begin
			eye[i] = c.eye[i];
			up[i] = c.up[i];
			d[i] = eye[i] - 64'(c.tgt[i]);
		end
		if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
			for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? ONE_Q16 : 32'sd0;
		end else begin
			unit_vec(d, z);
			cross_full(up, z, t);
			unit_vec(t, x);
			cross_full(z, x, t);
			unit_vec(t, y);
			for (int i = 0; i < 3; i++) begin
				m[4 * i] = 32'(x[i]);
				m[4 * i + 1] = 32'(y[i]);
				m[4 * i + 2] = 32'(z[i]);
				m[4 * i + 3] = 0;
			end
			m[12] = eye_offset(x, eye);
			m[13] = eye_offset(y, eye);
			m[14] = eye_offset(z, eye);
			m[15] = ONE_Q16;
		end
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 4; i++) b.e[i] = m[4 * k + i];
			b.last = (k == 3);
			pending_beats.push_back(b);
		end
	endtask

	// Check each beat against the oldest expectation.
	always @(posedge clk) begin
		matrix_beat_t x;
		if (arst_n && strobe) begin
			beats_seen++;
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %h %h %h %h",
					elem_a, elem_b, elem_c, elem_d);
			end else begin
				x = pending_beats.pop_front();
				if (x.e[0] !== elem_a || x.e[1] !== elem_b || x.e[2] !== elem_c ||
						x.e[3] !== elem_d || x.last !== last_group) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat mismatch: exp %h %h %h %h %b got %h %h %h %h %b",
							x.e[0], x.e[1], x.e[2], x.e[3], x.last,
							elem_a, elem_b, elem_c, elem_d, last_group);
				end
			end
		end
	end

	function automatic logic signed [31:0] rand_field();
		case ($urandom_range(0, 5))
			0: return $signed($urandom);
			1: return $signed($urandom_range(0, 8)) << $urandom_range(0, 31);
			2: return -($signed($urandom_range(0, 1 << 20)));
			3: return $signed($urandom_range(0, 1 << 20));
			4: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 255)) - 128;
		endcase
	endfunction

	function automatic view_cmd_t rand_cmd();
		view_cmd_t c;
		for (int i = 0; i < 3; i++) begin
			c.eye[i] = rand_field();
			c.tgt[i] = rand_field();
			c.up[i] = rand_field();
		end
		case ($urandom_range(0, 9))
			0: c.tgt = c.eye;
			1: c.up = c.eye;
			2: for (int i = 0; i < 3; i++) c.up[i] = c.eye[i] - c.tgt[i];
			default: ;
		endcase
		return c;
	endfunction

	// Hold the command until it is taken as a beat; typed rows expect the identity.
	task automatic send_cmd(input view_cmd_t c, input bit typed);
		matrix_beat_t b;
		@(negedge clk);
		{eye_x, eye_y, eye_z} = {c.eye[0], c.eye[1], c.eye[2]};
		{target_x, target_y, target_z} = {c.tgt[0], c.tgt[1], c.tgt[2]};
		{upward_x, upward_y, upward_z} = {c.up[0], c.up[1], c.up[2]};
		start = 1'b1;
		do @(posedge clk); while (busy);
		if (typed) begin
			b = '{'{ONE_Q16, 0, 0, 0}, 1'b0};
			pending_beats.push_back(b);
			b = '{'{0, ONE_Q16, 0, 0}, 1'b0};
			pending_beats.push_back(b);
			b = '{'{0, 0, ONE_Q16, 0}, 1'b0};
			pending_beats.push_back(b);
			b = '{'{0, 0, 0, ONE_Q16}, 1'b1};
			pending_beats.push_back(b);
		end else begin
			predict_view(c);
		end
	endtask

	task automatic drop_start();
		@(negedge clk);
		start = 1'b0;
	endtask

	localparam int DIR_ROWS = 12;
	localparam logic signed [31:0] MAXP = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MAXN = 32'sh8000_0000;

	initial begin
		view_cmd_t dir_rows [DIR_ROWS];
		int        burst;
		int        wait_cycles;
		arst_n = 1'b0;
		start = 1'b0;
		{eye_x, eye_y, eye_z, target_x, target_y, target_z} = '0;
		{upward_x, upward_y, upward_z} = '0;
		mismatches = 0;
		beats_seen = 0;
		// rows 0 and 1 have eye on target: identity typed in; then extremes,
		// zero up, parallel up
		dir_rows[0] = '{'{0, 0, 0}, '{0, 0, 0}, '{0, 65536, 0}};
		dir_rows[1] = '{'{MAXP, MAXN, 5}, '{MAXP, MAXN, 5}, '{1, 2, 3}};
		dir_rows[2] = '{'{0, 0, 65536}, '{0, 0, 0}, '{0, 65536, 0}};
		dir_rows[3] = '{'{MAXP, MAXP, MAXP}, '{MAXN, MAXN, MAXN}, '{MAXP, MAXN, MAXP}};
		dir_rows[4] = '{'{MAXN, MAXN, MAXN}, '{MAXP, MAXP, MAXP}, '{MAXN, MAXP, MAXN}};
		dir_rows[5] = '{'{0, 0, 1}, '{0, 0, 0}, '{0, 0, 0}};
		dir_rows[6] = '{'{0, 0, 65536}, '{0, 0, 0}, '{0, 0, 65536}};
		dir_rows[7] = '{'{MAXP, 0, 0}, '{MAXN, 0, 0}, '{0, 65536, 0}};
		dir_rows[8] = '{'{-1, -1, -1}, '{0, 0, 0}, '{MAXP, MAXN, 1}};
		dir_rows[9] = '{'{MAXP, MAXP, MAXP}, '{0, 0, 0}, '{0, 65536, 0}};
		dir_rows[10] = '{'{MAXN, MAXN, MAXN}, '{MAXP, 0, 0}, '{-1, -1, -1}};
		dir_rows[11] = '{'{12345, -678, 90}, '{-3, 4, -5}, '{-1, MAXN, MAXP}};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[r]) send_cmd(dir_rows[r], r < 2);
		drop_start();
		// Let the directed rows drain.
		while (pending_beats.size() != 0) @(posedge clk);

		for (int n = 0; n < 470; ) begin
			burst = $urandom_range(1, 6);
			for (int j = 0; j < burst && n < 470; j++, n++) send_cmd(rand_cmd(), 1'b0);
			drop_start();
			if (n > 200 && n < 210) begin
				while (pending_beats.size() != 0) @(posedge clk);
			end else if ($urandom_range(0, 2) != 0) begin
				repeat ($urandom_range(0, 40)) @(posedge clk);
			end
		end

		wait_cycles = 0;
		while (pending_beats.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (600) @(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/lavm_pkg.sv
sv/lavm_front.sv
sv/lavm_queue.sv
sv/lavm_back.sv
sv/look_at_view_matrix_top.sv
verif/look_at_view_matrix_top_tb.sv
